>>> hdl/fdmm_pkg.sv
// ----------------------------------------------------------------------------
// Frame difference motion mask package
// Shared types, constants and the reciprocal table of the box blur divider.
// ----------------------------------------------------------------------------
package fdmm_pkg;

  localparam int MaxWidthDef  = 640;
  localparam int MaxHeightDef = 480;
  localparam int MaxRadiusDef = 7;

  // Register reset values.
  localparam logic [9:0] WidthRst     = 10'd640;
  localparam logic [8:0] HeightRst    = 9'd480;
  localparam logic [2:0] RadiusRst    = 3'd1;
  localparam logic [7:0] ThresholdRst = 8'd25;

  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 10;

  // Luma weights in 16-bit fixed point.
  localparam logic [23:0] GrayWr = 24'd19595;
  localparam logic [23:0] GrayWg = 24'd38470;
  localparam logic [23:0] GrayWb = 24'd7471;

  // Window sums are divided by (2r+1)^2 as a multiply by ceil(2^DivShift / d).
  // Radius zero divides by one and bypasses the table.
  localparam int DivShift = 28;
  localparam int RecipW   = 25;
  localparam logic [RecipW-1:0] RecipTab [16] = '{
    25'd0,
    25'((2**28 + 9 - 1) / 9),
    25'((2**28 + 25 - 1) / 25),
    25'((2**28 + 49 - 1) / 49),
    25'((2**28 + 81 - 1) / 81),
    25'((2**28 + 121 - 1) / 121),
    25'((2**28 + 169 - 1) / 169),
    25'((2**28 + 225 - 1) / 225),
    25'((2**28 + 289 - 1) / 289),
    25'((2**28 + 361 - 1) / 361),
    25'((2**28 + 441 - 1) / 441),
    25'((2**28 + 529 - 1) / 529),
    25'((2**28 + 625 - 1) / 625),
    25'((2**28 + 729 - 1) / 729),
    25'((2**28 + 841 - 1) / 841),
    25'((2**28 + 961 - 1) / 961)
  };

  typedef enum logic [CfgIndexW-1:0] {
    CFG_FRAME_WIDTH,
    CFG_FRAME_HEIGHT,
    CFG_BLUR_RADIUS,
    CFG_MOTION_THRESHOLD
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_COL,
    ST_COLEND,
    ST_SHIFT,
    ST_DIV,
    ST_CMP
  } state_e;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } pixel_t;

  typedef struct packed {
    logic [9:0] pos_x;
    logic [8:0] pos_y;
    logic       motion;
    logic       frame_end;
  } result_t;

  typedef struct packed {
    logic en;
    logic clr;
  } cell_ctrl_t;

endpackage

>>> hdl/frame_difference_motion_mask_unit.sv
// ----------------------------------------------------------------------------
// Frame difference motion mask unit
// Gray conversion, box blur over a column-sum chain, and comparison against
// the blurred previous frame. Emits one result per interior pixel.
// ----------------------------------------------------------------------------
// A pixel beat is accepted only in the idle state. Each pixel is written to the
// line store; from line 2r on, the 2r+1 window rows are read, one row per cycle,
// and shifted into the chain, and from column 2r on the sum is divided and
// compared, waiting for a free output register; only then is the next beat taken.
// Reset clears the control state, loads the register reset values and marks
// the first frame; both memories start undefined and need no clearing pass.
module frame_difference_motion_mask_unit #(
  parameter int MAX_WIDTH  = fdmm_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = fdmm_pkg::MaxHeightDef,
  parameter int MAX_RADIUS = fdmm_pkg::MaxRadiusDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  fdmm_pkg::pixel_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output fdmm_pkg::result_t                 out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fdmm_pkg::CfgIndexW-1:0]    cfg_index_i,
  input  logic [fdmm_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int WL   = 2 * MAX_RADIUS + 1;
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HH   = $clog2(MAX_HEIGHT + 1);
  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT);
  localparam int RW   = $clog2(MAX_RADIUS + 1);
  localparam int SW   = $clog2(WL);
  localparam int CW   = $clog2(WL * 255 + 1);
  localparam int HW   = $clog2(WL * WL * 255 + 1);
  localparam int PW   = HW + fdmm_pkg::RecipW;
  localparam int PD   = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW   = $clog2(PD);
  localparam int LD   = WL * MAX_WIDTH;
  localparam int LAW  = $clog2(LD);

  // Configuration registers.
  logic [9:0] cfg_w_q;
  logic [8:0] cfg_h_q;
  logic [2:0] cfg_r_q;
  logic [7:0] cfg_thr_q;
  logic       cfg_we;
  logic       size_write;

  logic [WW-1:0] eff_w;
  logic [HH-1:0] eff_h;
  logic [RW-1:0] eff_r;
  logic [RW:0]   two_r;

  // Position counters.
  logic [XW-1:0] col_q;
  logic [YW-1:0] row_q;
  logic [AW-1:0] addr_q;
  logic [SW-1:0] slot_q;
  logic          first_q;

  // Item in flight.
  logic [XW-1:0] it_x_q;
  logic [YW-1:0] it_y_q;
  logic [AW-1:0] it_addr_q;
  logic [SW-1:0] it_slot_q;
  logic          it_first_q;
  logic          it_end_q;
  logic [7:0]    gray_q;
  logic [23:0]   gray_sum;

  logic [AW-1:0] rw_q;
  logic [SW-1:0] rd_row_q;
  logic [SW-1:0] ky_q;
  logic          rvalid_q;
  logic [CW-1:0] acc_q;
  logic [HW-1:0] hsum_q;
  logic [PW-1:0] prod_q;
  logic [AW-1:0] pos_q;

  logic              out_valid_q;
  fdmm_pkg::result_t out_q;

  fdmm_pkg::state_e state_q, state_d;

  logic accept;
  logic line_we, line_re, prev_we, prev_re, shift_en, load_out;
  logic border;

  logic [LAW-1:0] line_waddr, line_raddr;
  logic [7:0]     line_rdata;
  logic [AW-1:0]  prev_waddr, prev_raddr;
  logic [7:0]     prev_wdata, prev_rdata;

  logic [7:0] blur, diff;

  fdmm_pkg::cell_ctrl_t cell_ctrl [WL];
  logic [CW-1:0]        cell_q [WL];
  logic [CW-1:0]        leave;

  // Effective register values.
  always_comb begin
    if (cfg_w_q == '0) begin
      eff_w = WW'(1);
    end else if (int'(cfg_w_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(cfg_w_q);
    end
    if (cfg_h_q == '0) begin
      eff_h = HH'(1);
    end else if (int'(cfg_h_q) > MAX_HEIGHT) begin
      eff_h = HH'(MAX_HEIGHT);
    end else begin
      eff_h = HH'(cfg_h_q);
    end
    if (int'(cfg_r_q) > MAX_RADIUS) begin
      eff_r = RW'(MAX_RADIUS);
    end else begin
      eff_r = RW'(cfg_r_q);
    end
    two_r = {eff_r, 1'b0};
  end

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign size_write  = cfg_we &&
                       (fdmm_pkg::cfg_idx_e'(cfg_index_i) == fdmm_pkg::CFG_FRAME_WIDTH ||
                        fdmm_pkg::cfg_idx_e'(cfg_index_i) == fdmm_pkg::CFG_FRAME_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q   <= fdmm_pkg::WidthRst;
      cfg_h_q   <= fdmm_pkg::HeightRst;
      cfg_r_q   <= fdmm_pkg::RadiusRst;
      cfg_thr_q <= fdmm_pkg::ThresholdRst;
    end else if (cfg_we) begin
      case (fdmm_pkg::cfg_idx_e'(cfg_index_i))
        fdmm_pkg::CFG_FRAME_WIDTH:      cfg_w_q   <= cfg_data_i[9:0];
        fdmm_pkg::CFG_FRAME_HEIGHT:     cfg_h_q   <= cfg_data_i[8:0];
        fdmm_pkg::CFG_BLUR_RADIUS:      cfg_r_q   <= cfg_data_i[2:0];
        fdmm_pkg::CFG_MOTION_THRESHOLD: cfg_thr_q <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready_o = (state_q == fdmm_pkg::ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  assign gray_sum = fdmm_pkg::GrayWr * {16'd0, in_data_i.pixel_red} +
                    fdmm_pkg::GrayWg * {16'd0, in_data_i.pixel_green} +
                    fdmm_pkg::GrayWb * {16'd0, in_data_i.pixel_blue};

  // Position counters advance on every accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      addr_q  <= '0;
      slot_q  <= '0;
      first_q <= 1'b1;
    end else begin
      if (accept) begin
        if (int'(col_q) + 1 >= int'(eff_w)) begin
          col_q <= '0;
          if (int'(row_q) + 1 >= int'(eff_h)) begin
            row_q   <= '0;
            addr_q  <= '0;
            slot_q  <= '0;
            first_q <= 1'b0;
          end else begin
            row_q  <= row_q + YW'(1);
            addr_q <= addr_q + AW'(1);
            slot_q <= (int'(slot_q) == WL - 1) ? '0 : slot_q + SW'(1);
          end
        end else begin
          col_q  <= col_q + XW'(1);
          addr_q <= addr_q + AW'(1);
        end
      end
      if (size_write) begin
        col_q   <= '0;
        row_q   <= '0;
        addr_q  <= '0;
        slot_q  <= '0;
        first_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      it_x_q     <= col_q;
      it_y_q     <= row_q;
      it_addr_q  <= addr_q;
      it_slot_q  <= slot_q;
      it_first_q <= first_q;
      it_end_q   <= (int'(col_q) == int'(eff_w) - 1) && (int'(row_q) == int'(eff_h) - 1);
      gray_q     <= gray_sum[23:16];
    end
  end

  assign border = (int'(it_x_q) < int'(eff_r)) ||
                  (int'(it_x_q) + int'(eff_r) >= int'(eff_w)) ||
                  (int'(it_y_q) < int'(eff_r)) ||
                  (int'(it_y_q) + int'(eff_r) >= int'(eff_h));

  assign leave = cell_q[$clog2(WL)'(two_r)];

  always_comb begin
    if (eff_r == '0) begin
      blur = hsum_q[7:0];
    end else begin
      blur = prod_q[fdmm_pkg::DivShift +: 8];
    end
    diff = (blur > prev_rdata) ? blur - prev_rdata : prev_rdata - blur;
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fdmm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    line_we  = 1'b0;
    line_re  = 1'b0;
    prev_we  = 1'b0;
    prev_re  = 1'b0;
    shift_en = 1'b0;
    load_out = 1'b0;
    case (state_q)
      fdmm_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = fdmm_pkg::ST_WRITE;
        end
      end
      fdmm_pkg::ST_WRITE: begin
        line_we = 1'b1;
        prev_we = border;
        state_d = (int'(it_y_q) >= int'(two_r)) ? fdmm_pkg::ST_COL : fdmm_pkg::ST_IDLE;
      end
      fdmm_pkg::ST_COL: begin
        line_re = 1'b1;
        if (int'(ky_q) == int'(two_r)) begin
          state_d = fdmm_pkg::ST_COLEND;
        end
      end
      fdmm_pkg::ST_COLEND: begin
        state_d = fdmm_pkg::ST_SHIFT;
      end
      fdmm_pkg::ST_SHIFT: begin
        shift_en = 1'b1;
        state_d  = (int'(it_x_q) >= int'(two_r)) ? fdmm_pkg::ST_DIV : fdmm_pkg::ST_IDLE;
      end
      fdmm_pkg::ST_DIV: begin
        prev_re = 1'b1;
        state_d = fdmm_pkg::ST_CMP;
      end
      fdmm_pkg::ST_CMP: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          prev_we  = 1'b1;
          state_d  = fdmm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fdmm_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == fdmm_pkg::ST_WRITE) begin
      rw_q <= AW'(eff_r) * AW'(eff_w) + AW'(eff_r);
      ky_q <= '0;
      if (int'(it_slot_q) >= int'(two_r)) begin
        rd_row_q <= SW'(int'(it_slot_q) - int'(two_r));
      end else begin
        rd_row_q <= SW'(int'(it_slot_q) + WL - int'(two_r));
      end
    end
    if (line_re) begin
      ky_q     <= ky_q + SW'(1);
      rd_row_q <= (int'(rd_row_q) == WL - 1) ? '0 : rd_row_q + SW'(1);
    end
    if (state_q == fdmm_pkg::ST_WRITE) begin
      acc_q <= '0;
    end else if (rvalid_q) begin
      acc_q <= acc_q + CW'(line_rdata);
    end
    if (shift_en) begin
      if (it_x_q == '0) begin
        hsum_q <= HW'(acc_q);
      end else begin
        hsum_q <= hsum_q + HW'(acc_q) - HW'(leave);
      end
    end
    if (state_q == fdmm_pkg::ST_DIV) begin
      prod_q <= PW'(hsum_q) * PW'(fdmm_pkg::RecipTab[4'(eff_r)]);
      pos_q  <= it_addr_q - rw_q;
    end
    if (load_out) begin
      out_q.pos_x     <= 10'(it_x_q - XW'(eff_r));
      out_q.pos_y     <= 9'(it_y_q - YW'(eff_r));
      out_q.motion    <= !it_first_q && (diff > cfg_thr_q);
      out_q.frame_end <= it_end_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rvalid_q <= line_re;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Line store of the last window lines of gray values.
  assign line_waddr = LAW'(it_slot_q) * LAW'(MAX_WIDTH) + LAW'(it_x_q);
  assign line_raddr = LAW'(rd_row_q) * LAW'(MAX_WIDTH) + LAW'(it_x_q);

  fdmm_ram #(
    .DataW(8),
    .Depth(LD)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (line_we),
    .waddr_i(line_waddr),
    .wdata_i(gray_q),
    .re_i   (line_re),
    .raddr_i(line_raddr),
    .rdata_o(line_rdata)
  );

  // Blurred previous frame; border positions are written black.
  assign prev_waddr = (state_q == fdmm_pkg::ST_WRITE) ? it_addr_q : pos_q;
  assign prev_wdata = (state_q == fdmm_pkg::ST_WRITE) ? 8'd0 : blur;
  assign prev_raddr = it_addr_q - rw_q;

  fdmm_ram #(
    .DataW(8),
    .Depth(PD)
  ) u_prev_ram (
    .clk_i  (clk_i),
    .we_i   (prev_we),
    .waddr_i(prev_waddr),
    .wdata_i(prev_wdata),
    .re_i   (prev_re),
    .raddr_i(prev_raddr),
    .rdata_o(prev_rdata)
  );

  // Column sum chain; it restarts at the first column of each line.
  for (genvar k = 0; k < WL; k++) begin : g_cell
    logic [CW-1:0] cell_d;
    if (k == 0) begin : g_head
      assign cell_d            = acc_q;
      assign cell_ctrl[k].clr  = 1'b0;
    end else begin : g_body
      assign cell_d            = cell_q[k-1];
      assign cell_ctrl[k].clr  = (it_x_q == '0);
    end
    assign cell_ctrl[k].en = shift_en;

    fdmm_cell #(
      .DataW(CW)
    ) u_cell (
      .clk_i (clk_i),
      .ctrl_i(cell_ctrl[k]),
      .d_i   (cell_d),
      .q_o   (cell_q[k])
    );
  end

  // The position counters stay inside the frame in use.
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(col_q) < int'(eff_w))
    else $error("column counter outside frame width");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(row_q) < int'(eff_h))
    else $error("line counter outside frame height");

  // The column read never runs past the window height.
  a_ky_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fdmm_pkg::ST_COL) |-> (int'(ky_q) <= int'(two_r)))
    else $error("column read beyond window");

  // A result is only loaded when the output register is free or draining.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_q)))
    else $error("pending result overwritten");

endmodule

>>> hdl/fdmm_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fdmm_ram #(
  parameter int DataW = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataW-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [DataW-1:0]         rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/fdmm_cell.sv
// ----------------------------------------------------------------------------
// Column sum cell
// One stage of the horizontal window chain; holds the vertical sum of one
// window column and passes it on at every shift; a shift with clear loads zero.
// ----------------------------------------------------------------------------
module fdmm_cell #(
  parameter int DataW = 12
) (
  input  logic                clk_i,
  input  fdmm_pkg::cell_ctrl_t ctrl_i,
  input  logic [DataW-1:0]    d_i,
  output logic [DataW-1:0]    q_o
);

  logic [DataW-1:0] sum_q;
  logic [DataW-1:0] sum_d;

  always_comb begin
    sum_d = sum_q;
    if (ctrl_i.en) begin
      sum_d = ctrl_i.clr ? '0 : d_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  assign q_o = sum_q;

endmodule
